// ----- rtl/ptm_pkg.sv -----
// shared constants, types and tables of the tunnel texture mapper
// depends on nothing; used by every module under rtl
package ptm_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int TEX_SIZE      = 256;

  localparam int DIV_STEPS    = 27;
  localparam int SQRT_STEPS   = 14;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_SCALE = 24;
  localparam int ANGLE_FRAC   = 16;

  localparam int DEPTH_LAT  = 1 + DIV_STEPS + SQRT_STEPS;
  localparam int CORDIC_LAT = 1 + CORDIC_STEPS;
  localparam int ANGLE_PAD  = DEPTH_LAT - CORDIC_LAT;

  localparam logic [13:0] DEPTH_MAX = 14'd8192;

  typedef logic signed [35:0] cvec_t;
  typedef logic signed [26:0] angle_t;

  localparam angle_t HALF_TURN    = 27'sd16777216;
  localparam angle_t QUARTER_TURN = 27'sd8388608;

  typedef enum logic [1:0] {
    REG_SCROLL_X,
    REG_SCROLL_Y,
    REG_HOLE_THRESHOLD,
    REG_HOLE_COLOR
  } reg_idx_t;

  typedef struct packed {
    logic        req;
    logic [15:0] addr;
    logic [7:0]  value;
  } side_t;

  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [15:0] addr;
    logic [7:0]  data;
  } tm_req_t;

  function automatic angle_t atan_unit(input int i);
    angle_t r;
    case (i)
      0:  r = 27'sd4194304;
      1:  r = 27'sd2476042;
      2:  r = 27'sd1308273;
      3:  r = 27'sd664100;
      4:  r = 27'sd333339;
      5:  r = 27'sd166832;
      6:  r = 27'sd83436;
      7:  r = 27'sd41721;
      8:  r = 27'sd20861;
      9:  r = 27'sd10430;
      10: r = 27'sd5215;
      11: r = 27'sd2608;
      12: r = 27'sd1304;
      13: r = 27'sd652;
      14: r = 27'sd326;
      15: r = 27'sd163;
      16: r = 27'sd81;
      17: r = 27'sd41;
      18: r = 27'sd20;
      19: r = 27'sd10;
      20: r = 27'sd5;
      21: r = 27'sd3;
      22: r = 27'sd1;
      23: r = 27'sd1;
      default: r = 27'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ptm_depth.sv -----
// depth pipeline: restoring divide of 2^26 by s, then digit-by-digit square root
// depends on ptm_pkg
module ptm_depth (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] s,
  output logic [13:0] depth
);

  logic [17:0] in_s;
  logic        in_zero;

  logic [17:0] d_s    [0:ptm_pkg::DIV_STEPS-1];
  logic [17:0] d_rem  [0:ptm_pkg::DIV_STEPS-1];
  logic [26:0] d_q    [0:ptm_pkg::DIV_STEPS-1];
  logic        d_zero [0:ptm_pkg::DIV_STEPS-1];

  logic [27:0] r_v    [0:ptm_pkg::SQRT_STEPS-1];
  logic [15:0] r_rem  [0:ptm_pkg::SQRT_STEPS-1];
  logic [13:0] r_root [0:ptm_pkg::SQRT_STEPS-1];
  logic        r_zero [0:ptm_pkg::SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      in_s    <= s;
      in_zero <= (s == 18'd0);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < ptm_pkg::DIV_STEPS; k++) begin : g_div
    logic [17:0] s_in;
    logic [17:0] rem_in;
    logic [26:0] q_in;
    logic        zero_in;
    logic        dbit;
    logic [18:0] trial;
    logic [18:0] diff;
    if (k == 0) begin : g_first
      assign s_in    = in_s;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign zero_in = in_zero;
      assign dbit    = 1'b1;
    end else begin : g_next
      assign s_in    = d_s[k-1];
      assign rem_in  = d_rem[k-1];
      assign q_in    = d_q[k-1];
      assign zero_in = d_zero[k-1];
      assign dbit    = 1'b0;
    end
    assign trial = {rem_in, dbit};
    assign diff  = trial - {1'b0, s_in};
    always_ff @(posedge clk) begin
      if (en) begin
        d_s[k]    <= s_in;
        d_zero[k] <= zero_in;
        if (trial >= {1'b0, s_in}) begin
          d_rem[k] <= diff[17:0];
          d_q[k]   <= {q_in[25:0], 1'b1};
        end else begin
          d_rem[k] <= trial[17:0];
          d_q[k]   <= {q_in[25:0], 1'b0};
        end
      end
    end
  end

  // one root bit per stage from two radicand bits
  for (genvar j = 0; j < ptm_pkg::SQRT_STEPS; j++) begin : g_sqrt
    logic [27:0] v_in;
    logic [15:0] rem_in;
    logic [13:0] root_in;
    logic        zero_in;
    logic [17:0] cur;
    logic [17:0] trial;
    logic [17:0] diff;
    if (j == 0) begin : g_first
      assign v_in    = {1'b0, d_q[ptm_pkg::DIV_STEPS-1]};
      assign rem_in  = '0;
      assign root_in = '0;
      assign zero_in = d_zero[ptm_pkg::DIV_STEPS-1];
    end else begin : g_next
      assign v_in    = r_v[j-1];
      assign rem_in  = r_rem[j-1];
      assign root_in = r_root[j-1];
      assign zero_in = r_zero[j-1];
    end
    assign cur   = {rem_in, v_in[27-2*j -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cur - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        r_v[j]    <= v_in;
        r_zero[j] <= zero_in;
        if (cur >= trial) begin
          r_rem[j]  <= diff[15:0];
          r_root[j] <= {root_in[12:0], 1'b1};
        end else begin
          r_rem[j]  <= cur[15:0];
          r_root[j] <= {root_in[12:0], 1'b0};
        end
      end
    end
  end

  assign depth = r_zero[ptm_pkg::SQRT_STEPS-1] ? ptm_pkg::DEPTH_MAX
                                               : r_root[ptm_pkg::SQRT_STEPS-1];

endmodule

// ----- rtl/ptm_cordic.sv -----
// vectoring cordic pipeline giving the low byte of the truncated angle
// depends on ptm_pkg
module ptm_cordic (
  input  logic              clk,
  input  logic              en,
  input  logic signed [9:0] dx,
  input  logic signed [8:0] dy,
  output logic [7:0]        angle
);

  ptm_pkg::cvec_t  pre_px;
  ptm_pkg::cvec_t  pre_py;
  ptm_pkg::angle_t pre_z;
  ptm_pkg::cvec_t  c0_px;
  ptm_pkg::cvec_t  c0_py;
  ptm_pkg::angle_t c0_z;

  ptm_pkg::cvec_t  c_px [0:ptm_pkg::CORDIC_STEPS-1];
  ptm_pkg::cvec_t  c_py [0:ptm_pkg::CORDIC_STEPS-1];
  ptm_pkg::angle_t c_z  [0:ptm_pkg::CORDIC_STEPS-1];

  ptm_pkg::cvec_t  ex;
  ptm_pkg::cvec_t  ey;
  ptm_pkg::angle_t z_out;
  ptm_pkg::angle_t z_mag;
  logic [10:0]     z_int;

  assign ex = ptm_pkg::cvec_t'(dx);
  assign ey = ptm_pkg::cvec_t'(dy);

  // turn into the right half plane first
  always_comb begin
    pre_px = ey;
    pre_py = ex;
    pre_z  = '0;
    if (dy < 0) begin
      pre_z  = (dx >= 0) ? ptm_pkg::HALF_TURN : -ptm_pkg::HALF_TURN;
      pre_px = -ey;
      pre_py = -ex;
    end else if (dy == 0) begin
      pre_py = '0;
      if (dx > 0) begin
        pre_z  = ptm_pkg::QUARTER_TURN;
        pre_px = ex;
      end else if (dx < 0) begin
        pre_z  = -ptm_pkg::QUARTER_TURN;
        pre_px = -ex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_px <= pre_px <<< ptm_pkg::CORDIC_SCALE;
      c0_py <= pre_py <<< ptm_pkg::CORDIC_SCALE;
      c0_z  <= pre_z;
    end
  end

  for (genvar i = 0; i < ptm_pkg::CORDIC_STEPS; i++) begin : g_iter
    ptm_pkg::cvec_t  px_in;
    ptm_pkg::cvec_t  py_in;
    ptm_pkg::angle_t z_in;
    if (i == 0) begin : g_first
      assign px_in = c0_px;
      assign py_in = c0_py;
      assign z_in  = c0_z;
    end else begin : g_next
      assign px_in = c_px[i-1];
      assign py_in = c_py[i-1];
      assign z_in  = c_z[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (py_in == 0) begin
          // settled on the axis, hold
          c_px[i] <= px_in;
          c_py[i] <= py_in;
          c_z[i]  <= z_in;
        end else if (py_in > 0) begin
          c_px[i] <= px_in + (py_in >>> i);
          c_py[i] <= py_in - (px_in >>> i);
          c_z[i]  <= z_in + ptm_pkg::atan_unit(i);
        end else begin
          c_px[i] <= px_in - (py_in >>> i);
          c_py[i] <= py_in + (px_in >>> i);
          c_z[i]  <= z_in - ptm_pkg::atan_unit(i);
        end
      end
    end
  end

  // drop the fraction, rounding toward zero
  assign z_out = c_z[ptm_pkg::CORDIC_STEPS-1];
  assign z_mag = (z_out < 0) ? -z_out : z_out;
  assign z_int = z_mag[26:ptm_pkg::ANGLE_FRAC];
  assign angle = (z_out < 0) ? 8'(-z_int[7:0]) : z_int[7:0];

endmodule

// ----- rtl/ptm_texmem.sv -----
// 256x256 byte texture store, one write or one registered read per cycle while en is high
// depends on ptm_pkg
module ptm_texmem (
  input  logic             clk,
  input  logic             en,
  input  ptm_pkg::tm_req_t acc,
  output logic [7:0]       rdata
);

  logic [7:0] mem [0:ptm_pkg::TEX_SIZE*ptm_pkg::TEX_SIZE-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc.wr) begin
        mem[acc.addr] <= acc.data;
      end else if (acc.rd) begin
        rdata <= mem[acc.addr];
      end
    end
  end

endmodule

// ----- rtl/polar_tunnel_texture_mapper.sv -----
// top level of the tunnel texture mapper: handshake, registers, pipeline glue
// depends on ptm_pkg, ptm_depth, ptm_cordic, ptm_texmem

// One item enters per clock cycle while req_stall is low. A texel write
// item travels the same pipeline as a pixel item and updates the texture
// store at the same stage where pixels read it, so reads and writes keep
// their item order. The pipeline follows the depth path: the input stage,
// the depth input register, 27 divide stages (one quotient bit each), 14
// square root stages, then a lookup stage and the texture store read.
// The angle cordic (25 stages) runs alongside and is delayed to match.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Configuration registers must only be written while the pipeline is empty.
module polar_tunnel_texture_mapper (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [8:0]  pix_x,
  input  logic [7:0]  pix_y,
  input  logic [15:0] texel_addr,
  input  logic [7:0]  texel_value,
  // result output
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  color,
  output logic        is_hole,
  output logic [7:0]  tex_col,
  output logic [7:0]  tex_row,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // config registers
  logic [7:0]  scroll_x;
  logic [7:0]  scroll_y;
  logic [13:0] hole_threshold;
  logic [7:0]  hole_color;

  // global advance: everything moves unless a result is held back
  logic en;

  // input stage
  logic               a_valid;
  ptm_pkg::side_t     a_side;
  logic signed [9:0]  a_dx;
  logic signed [8:0]  a_dy;
  logic signed [19:0] sq_x;
  logic signed [17:0] sq_y;
  logic [19:0]        s_sum;

  // side band delay matched to depth path
  logic           sd_valid [0:ptm_pkg::DEPTH_LAT-1];
  ptm_pkg::side_t sd       [0:ptm_pkg::DEPTH_LAT-1];

  logic [13:0] depth;
  logic [7:0]  angle;
  logic [7:0]  ang_dly [0:ptm_pkg::ANGLE_PAD-1];

  // lookup stage
  logic        m_valid;
  logic        m_req;
  logic        m_hole;
  logic [7:0]  m_col;
  logic [7:0]  m_row;
  logic [15:0] m_addr;
  logic [7:0]  m_value;
  ptm_pkg::tm_req_t tm_acc;
  logic [7:0]  rdata;

  // result stage
  logic        o_valid;
  logic        o_hole;
  logic [7:0]  o_col;
  logic [7:0]  o_row;

  assign en        = !(o_valid && rsp_stall);
  assign req_stall = !en;

  // register writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x       <= '0;
      scroll_y       <= '0;
      hole_threshold <= 14'd819;
      hole_color     <= '0;
    end else if (psel && penable && pwrite) begin
      case (ptm_pkg::reg_idx_t'(paddr[3:2]))
        ptm_pkg::REG_SCROLL_X:       scroll_x       <= pwdata[7:0];
        ptm_pkg::REG_SCROLL_Y:       scroll_y       <= pwdata[7:0];
        ptm_pkg::REG_HOLE_THRESHOLD: hole_threshold <= pwdata[13:0];
        ptm_pkg::REG_HOLE_COLOR:     hole_color     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ptm_pkg::reg_idx_t'(paddr[3:2]))
      ptm_pkg::REG_SCROLL_X:       prdata = {24'd0, scroll_x};
      ptm_pkg::REG_SCROLL_Y:       prdata = {24'd0, scroll_y};
      ptm_pkg::REG_HOLE_THRESHOLD: prdata = {18'd0, hole_threshold};
      ptm_pkg::REG_HOLE_COLOR:     prdata = {24'd0, hole_color};
      default:                     prdata = '0;
    endcase
  end

  // input stage: offsets from the screen centre
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.req   <= req_type;
      a_side.addr  <= texel_addr;
      a_side.value <= texel_value;
      a_dx <= $signed({1'b0, pix_x}) - 10'(ptm_pkg::SCREEN_WIDTH / 2);
      a_dy <= $signed({1'b0, pix_y}) - 9'(ptm_pkg::SCREEN_HEIGHT / 2);
    end
  end

  // squared radius, always below 2^18
  assign sq_x  = a_dx * a_dx;
  assign sq_y  = a_dy * a_dy;
  assign s_sum = 20'(sq_x) + 20'(sq_y);

  ptm_depth u_depth (
    .clk   (clk),
    .en    (en),
    .s     (s_sum[17:0]),
    .depth (depth)
  );

  ptm_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .dx    (a_dx),
    .dy    (a_dy),
    .angle (angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ptm_pkg::DEPTH_LAT; k++) begin
        sd_valid[k] <= 1'b0;
      end
    end else if (en) begin
      sd_valid[0] <= a_valid;
      for (int k = 1; k < ptm_pkg::DEPTH_LAT; k++) begin
        sd_valid[k] <= sd_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]      <= a_side;
      ang_dly[0] <= angle;
      for (int k = 1; k < ptm_pkg::DEPTH_LAT; k++) begin
        sd[k] <= sd[k-1];
      end
      for (int k = 1; k < ptm_pkg::ANGLE_PAD; k++) begin
        ang_dly[k] <= ang_dly[k-1];
      end
    end
  end

  // lookup stage: wrap into the texture, hole test
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= sd_valid[ptm_pkg::DEPTH_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_req   <= sd[ptm_pkg::DEPTH_LAT-1].req;
      m_addr  <= sd[ptm_pkg::DEPTH_LAT-1].addr;
      m_value <= sd[ptm_pkg::DEPTH_LAT-1].value;
      m_col   <= depth[7:0] + scroll_x;
      m_row   <= ang_dly[ptm_pkg::ANGLE_PAD-1] + scroll_y;
      m_hole  <= (depth > hole_threshold);
    end
  end

  // writes and pixel reads meet the store in item order
  always_comb begin
    tm_acc.wr   = m_valid && !m_req;
    tm_acc.rd   = m_valid && m_req;
    tm_acc.addr = m_req ? {m_row, m_col} : m_addr;
    tm_acc.data = m_value;
  end

  ptm_texmem u_texmem (
    .clk   (clk),
    .en    (en),
    .acc   (tm_acc),
    .rdata (rdata)
  );

  // result stage, only pixel items give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= m_valid && m_req;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hole <= m_hole;
      o_col  <= m_col;
      o_row  <= m_row;
    end
  end

  assign rsp_valid = o_valid;
  assign color     = o_hole ? hole_color : rdata;
  assign is_hole   = o_hole;
  assign tex_col   = o_col;
  assign tex_row   = o_row;

  // hole pixels carry the hole colour
  a_hole_color : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_hole |-> color == hole_color)
    else $error("hole item without hole colour");

  // a held result freezes the lookup stage
  a_freeze : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(m_valid) && $stable(m_col) && $stable(m_row))
    else $error("pipeline moved while result held");

  // texel writes never make a result
  a_write_silent : assert property (@(posedge clk) disable iff (rst)
    en && m_valid && !m_req |=> !rsp_valid)
    else $error("write item produced a result");

endmodule
